### rtl/core/signed_divide_saturating_unit_macros.svh
// Assertion macros used by the checker module of this block.
`ifndef SIGNED_DIVIDE_SATURATING_UNIT_MACROS_SVH
`define SIGNED_DIVIDE_SATURATING_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDSU_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("sdsu assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SDSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sdsu assertion failed");

`endif

### rtl/core/sdsu_pkg.sv
package sdsu_pkg;

  // Default operand width.
  localparam int unsigned DataWidthDef = 32;

  // Per-cycle control broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic load;  // start a new division
    logic step;  // perform one shift and subtract step
    logic take;  // the trial subtraction fits this step
  } ctrl_t;

endpackage

### rtl/core/sdsu_cell.sv
module sdsu_cell
  import sdsu_pkg::*;
(
  input  logic  clk_i,
  input  ctrl_t ctrl_i,
  input  logic  shift_i,     // remainder bit handed up from the lower neighbor
  input  logic  num_i,       // dividend or quotient bit from the lower neighbor
  input  logic  num_load_i,  // dividend magnitude bit for this position
  input  logic  den_i,       // divisor magnitude bit for this position
  input  logic  borrow_i,    // borrow from the lower neighbor
  output logic  rem_o,
  output logic  num_o,
  output logic  borrow_o
);

  logic rem_q, rem_d;
  logic num_q, num_d;
  logic diff;

  // One bit of the trial subtraction of the divisor from the shifted remainder.
  assign diff     = shift_i ^ den_i ^ borrow_i;
  assign borrow_o = (~shift_i & den_i) | (~shift_i & borrow_i) | (den_i & borrow_i);

  // A step keeps the difference if the subtraction fits, else the shifted value.
  always_comb begin
    rem_d = rem_q;
    num_d = num_q;
    if (ctrl_i.load) begin
      rem_d = 1'b0;
      num_d = num_load_i;
    end else if (ctrl_i.step) begin
      rem_d = ctrl_i.take ? diff : shift_i;
      num_d = num_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
  end

  assign rem_o = rem_q;
  assign num_o = num_q;

endmodule

### rtl/core/signed_divide_saturating_unit.sv
// Signed integer divider, quotient truncated toward zero.
// Input channel: dividend_i and divisor_i, taken when in_valid_i and in_ready_o
// are both high. Output channel: quotient_o and div_by_zero_o, handed over
// when out_valid_o and out_ready_i are both high. One result per item.
// An item with a nonzero divisor is loaded into the row of bit cells, which
// forms one quotient bit per cycle; its result then moves to the output
// register. A zero divisor skips the row steps. A new item is taken only
// after the earlier one has left the row.
// A zero divisor raises div_by_zero_o with a zero quotient. The most negative
// value divided by minus one saturates to the largest positive value.
// The result sits in an output register, so a new item is taken while an
// earlier result still waits; if the receiver stalls, the finished quotient
// of the next item is held in the row until the output register frees up.
// Reset (rst_ni low) empties the block: no item pending, out_valid_o low.
module signed_divide_saturating_unit
  import sdsu_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DATA_WIDTH-1:0] dividend_i,
  input  logic signed [DATA_WIDTH-1:0] divisor_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] quotient_o,
  output logic                         div_by_zero_o
);

  localparam int unsigned CntW = $clog2(DATA_WIDTH);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  neg_q, zero_q;
  logic [DATA_WIDTH-1:0] den_q;
  logic                  out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] quot_q, quot_d;
  logic                  dbz_q;

  logic                  in_acc, out_free;
  logic [DATA_WIDTH-1:0] a_u, b_u, mag_a, mag_b;
  logic [DATA_WIDTH-1:0] rem_vec, num_vec, borrow_vec;
  logic [DATA_WIDTH-1:0] max_pos;
  ctrl_t                 ctrl;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  // Operand magnitudes in unsigned form.
  assign a_u   = DATA_WIDTH'(dividend_i);
  assign b_u   = DATA_WIDTH'(divisor_i);
  assign mag_a = a_u[DATA_WIDTH-1] ? (~a_u + 1'b1) : a_u;
  assign mag_b = b_u[DATA_WIDTH-1] ? (~b_u + 1'b1) : b_u;

  // Operand bookkeeping captured when an item is taken.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      den_q  <= mag_b;
      neg_q  <= a_u[DATA_WIDTH-1] ^ b_u[DATA_WIDTH-1];
      zero_q <= (b_u == '0);
    end
  end

  // Cell controls: the step fits when the carried-out top bit is set or no borrow.
  assign ctrl.load = in_acc;
  assign ctrl.step = (state_q == StRun);
  assign ctrl.take = rem_vec[DATA_WIDTH-1] | ~borrow_vec[DATA_WIDTH-1];

  // Row of bit cells: remainder and quotient bits move one place up each step.
  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    logic shift_in, num_in, borrow_in;
    if (i == 0) begin : g_low
      assign shift_in  = num_vec[DATA_WIDTH-1];
      assign num_in    = ctrl.take;
      assign borrow_in = 1'b0;
    end else begin : g_up
      assign shift_in  = rem_vec[i-1];
      assign num_in    = num_vec[i-1];
      assign borrow_in = borrow_vec[i-1];
    end

    sdsu_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .shift_i    (shift_in),
      .num_i      (num_in),
      .num_load_i (mag_a[i]),
      .den_i      (den_q[i]),
      .borrow_i   (borrow_in),
      .rem_o      (rem_vec[i]),
      .num_o      (num_vec[i]),
      .borrow_o   (borrow_vec[i])
    );
  end

  // Zero for a zero divisor, else sign correction and saturation of the quotient.
  assign max_pos = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  always_comb begin
    if (zero_q) begin
      quot_d = '0;
    end else if (neg_q) begin
      quot_d = ~num_vec + 1'b1;
    end else if (num_vec[DATA_WIDTH-1]) begin
      quot_d = max_pos;
    end else begin
      quot_d = num_vec;
    end
  end

  // Sequencer: one quotient bit per cycle, then hand the result over.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          cnt_d   = '0;
          state_d = (b_u == '0) ? StFin : StRun;
        end
      end
      StRun: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DATA_WIDTH - 1)) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register, loaded as the result leaves the row.
  always_ff @(posedge clk_i) begin
    if (state_q == StFin && out_free) begin
      quot_q <= quot_d;
      dbz_q  <= zero_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign quotient_o    = signed'(quot_q);
  assign div_by_zero_o = dbz_q;

endmodule

### rtl/core/sdsu_checker.sv
`include "signed_divide_saturating_unit_macros.svh"

module sdsu_checker
  import sdsu_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic signed [DATA_WIDTH-1:0] dividend_i,
  input logic signed [DATA_WIDTH-1:0] divisor_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic signed [DATA_WIDTH-1:0] quotient_o,
  input logic                         div_by_zero_o
);

  // A divide-by-zero result always carries a zero quotient.
  `SDSU_ASSERT_SAME(a_dbz_zero, clk_i, rst_ni, out_valid_o && div_by_zero_o, quotient_o == '0)

  // Only one item is in work at a time: taking one closes the input.
  `SDSU_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // A waiting input item keeps its operands until it is taken.
  `SDSU_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o,
                    in_valid_i && $stable(dividend_i) && $stable(divisor_i))

  // A stalled result holds its value.
  `SDSU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(quotient_o) && $stable(div_by_zero_o))

endmodule

bind signed_divide_saturating_unit sdsu_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sdsu_checker (.*);
